// ----- design/fbta_pkg.sv -----
// Shared types and constants of the frame time budget arbiter.
`default_nettype none
package fbta_pkg;

  // table and grant list sizes
  localparam int MAX_OWNERS = 16;
  localparam int GRANTS     = 2;
  localparam int IDX_W      = $clog2(MAX_OWNERS);
  localparam int CNT_W      = $clog2(MAX_OWNERS + 1);
  localparam int GCNT_W     = $clog2(GRANTS + 1);
  localparam int GIDX_W     = (GRANTS > 1) ? $clog2(GRANTS) : 1;

  // field widths
  localparam int ID_W  = 64;
  localparam int AMT_W = 32;
  localparam int BUD_W = 16;
  localparam int FRM_W = 64;

  // budget register indexes and reset values
  localparam logic [1:0] CFG_SEM_BUDGET   = 2'd0;
  localparam logic [1:0] CFG_PRE_BUDGET   = 2'd1;
  localparam logic [1:0] CFG_OWNER_BUDGET = 2'd2;
  localparam logic [BUD_W-1:0] GLOBAL_BUDGET_RST = 16'd2000;
  localparam logic [BUD_W-1:0] OWNER_BUDGET_RST  = 16'd1000;

  typedef enum logic [2:0] {
    ACT_REG       = 3'd0,
    ACT_UNREG     = 3'd1,
    ACT_SET_SEM   = 3'd2,
    ACT_SET_PRE   = 3'd3,
    ACT_CLAIM_SEM = 3'd4,
    ACT_CONS_SEM  = 3'd5,
    ACT_CLAIM_PRE = 3'd6,
    ACT_CONS_PRE  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // contents of one table cell
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             ps;
    logic             pp;
    logic [BUD_W-1:0] us;
    logic [BUD_W-1:0] up;
  } cell_data_t;

  // per-cell write strobes
  typedef struct packed {
    logic ld;   // take a new id, clear the rest
    logic sh;   // take the neighbor's contents
    logic clr;  // clear both used counters
    logic wps;  // write semantic pending
    logic wpp;  // write presentation pending
    logic wus;  // write semantic used
    logic wup;  // write presentation used
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- design/fbta_cell.sv -----
// One owner table cell: id, pending bits and used counters.
`default_nettype none
module fbta_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fbta_pkg::cell_ctl_t    ctl,
  input  wire fbta_pkg::cell_data_t   nbr,
  input  wire logic [fbta_pkg::ID_W-1:0]  new_id,
  input  wire logic                   pend_flag,
  input  wire logic [fbta_pkg::BUD_W-1:0] used_val,
  output fbta_pkg::cell_data_t        q
);

  logic [fbta_pkg::ID_W-1:0]  id_r;
  logic                       ps_r, pp_r;
  logic [fbta_pkg::BUD_W-1:0] us_r, up_r;

  // id payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.sh) begin
      id_r <= nbr.id;
    end else if (ctl.ld) begin
      id_r <= new_id;
    end
  end

  // pending bits and used counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= 1'b0;
      pp_r <= 1'b0;
      us_r <= '0;
      up_r <= '0;
    end else if (ctl.sh) begin
      ps_r <= nbr.ps;
      pp_r <= nbr.pp;
      us_r <= nbr.us;
      up_r <= nbr.up;
    end else if (ctl.ld) begin
      ps_r <= 1'b0;
      pp_r <= 1'b0;
      us_r <= '0;
      up_r <= '0;
    end else begin
      if (ctl.wps) ps_r <= pend_flag;
      if (ctl.wpp) pp_r <= pend_flag;
      if (ctl.clr) begin
        us_r <= '0;
        up_r <= '0;
      end else begin
        if (ctl.wus) us_r <= used_val;
        if (ctl.wup) up_r <= used_val;
      end
    end
  end

  assign q = '{id: id_r, ps: ps_r, pp: pp_r, us: us_r, up: up_r};

endmodule
`default_nettype wire

// ----- design/frame_time_budget_arbiter.sv -----
// Top level: owner table of cells, frame scan sequencer and claim/consume unit.
// Sequence: every item passes S_LOOK and S_EXEC, then goes to S_RESP for register,
// unregister and set pending, or through S_FIN to S_RESP for claim and consume; a
// new frame adds a clear state (S_FRAME) and a round-robin scan per class that
// visits up to count entries, one entry a cycle.
// Flow: one item at a time; the next accept comes in the cycle after the result is
// posted, later while a previous result is unread.
// Reset (rst_n, synchronous): table empty, counters and cursors zero,
// budgets 2000/2000/1000, last frame all ones.
`default_nettype none
module frame_time_budget_arbiter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // owner_id[63:0], pending_flag[64], amount_usec[96:65], frame_number[160:97]
  input  wire logic [167:0] in_tdata,
  // action[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // granted_usec[15:0], status[17:16]
  output logic [23:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata
);

  localparam int N   = fbta_pkg::MAX_OWNERS;
  localparam int G   = fbta_pkg::GRANTS;
  localparam int IW  = fbta_pkg::IDX_W;
  localparam int CW  = fbta_pkg::CNT_W;
  localparam int GCW = fbta_pkg::GCNT_W;
  localparam int GIW = fbta_pkg::GIDX_W;
  localparam int BW  = fbta_pkg::BUD_W;
  localparam int AW  = fbta_pkg::AMT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_FRAME = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // budgets
  logic [BW-1:0] sem_bud_r, pre_bud_r, own_bud_r;

  // latched item
  fbta_pkg::action_t             act_r;
  logic [fbta_pkg::ID_W-1:0]     id_r;
  logic                          flag_r;
  logic [AW-1:0]                 amt_r;
  logic [fbta_pkg::FRM_W-1:0]    frm_r;

  // table and frame state
  logic [CW-1:0]  count_r;
  logic [BW-1:0]  sem_tot_r, pre_tot_r;
  logic [IW-1:0]  sem_cur_r, pre_cur_r;
  logic [fbta_pkg::FRM_W-1:0] last_r;
  logic [GCW-1:0] sem_gcnt_r, pre_gcnt_r;
  logic [fbta_pkg::ID_W-1:0]  sem_gid_r [G];
  logic [fbta_pkg::ID_W-1:0]  pre_gid_r [G];

  // lookup
  logic [N-1:0]   match_r;
  logic           found_r;
  logic [IW-1:0]  kidx_r;

  // scan sequencer
  logic           sc_r;
  logic [IW-1:0]  idx_r;
  logic [CW-1:0]  seen_r;
  logic [GCW-1:0] gcnt_r;

  // result
  logic [BW-1:0]        res_g_r;
  fbta_pkg::status_t    res_st_r;
  logic                 out_v_r;
  logic [BW-1:0]        out_g_r;
  fbta_pkg::status_t    out_st_r;

  fbta_pkg::cell_data_t cq  [N];
  fbta_pkg::cell_ctl_t  ctl [N];
  logic [BW-1:0]        used_val;

  // saturating add against a budget
  function automatic logic [BW-1:0] sat_add(input logic [BW-1:0] u,
                                            input logic [AW-1:0] a,
                                            input logic [BW-1:0] b);
    logic [AW:0] s;
    s = {{(AW+1-BW){1'b0}}, u} + {1'b0, a};
    return (s > {{(AW+1-BW){1'b0}}, b}) ? b : s[BW-1:0];
  endfunction

  // budget minus the lesser of used and budget
  function automatic logic [BW-1:0] remain(input logic [BW-1:0] u,
                                           input logic [BW-1:0] b);
    return b - ((u < b) ? u : b);
  endfunction

  // cell row, each cell fed by its upper neighbor
  for (genvar i = 0; i < N; i++) begin : g_cell
    fbta_pkg::cell_data_t nb;
    if (i < N - 1) begin : g_mid
      assign nb = cq[i+1];
    end else begin : g_end
      assign nb = '0;
    end
    fbta_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[i]),
      .nbr       (nb),
      .new_id    (id_r),
      .pend_flag (flag_r),
      .used_val  (used_val),
      .q         (cq[i])
    );
  end

  // parallel id compare over the occupied cells
  logic [N-1:0]  matchv;
  logic [IW-1:0] kenc;
  always_comb begin
    kenc = '0;
    for (int i = 0; i < N; i++) begin
      matchv[i] = (CW'(i) < count_r) && (cq[i].id == id_r);
      if (matchv[i]) kenc = IW'(i);
    end
  end

  // selected cell fields by one-hot match
  logic          sel_ps, sel_pp;
  logic [BW-1:0] sel_us, sel_up;
  always_comb begin
    sel_ps = 1'b0;
    sel_pp = 1'b0;
    sel_us = '0;
    sel_up = '0;
    for (int i = 0; i < N; i++) begin
      sel_ps = sel_ps | (match_r[i] & cq[i].ps);
      sel_pp = sel_pp | (match_r[i] & cq[i].pp);
      sel_us = sel_us | ({BW{match_r[i]}} & cq[i].us);
      sel_up = sel_up | ({BW{match_r[i]}} & cq[i].up);
    end
  end

  // class decode and claim/consume arithmetic
  logic          is_sem, is_set, is_claim, new_frame, in_g;
  logic [BW-1:0] ou, tu, gb, own_rem, glob_rem, mrem, grant_v, tot_new, own_new;
  always_comb begin
    is_sem    = (act_r == fbta_pkg::ACT_CLAIM_SEM) || (act_r == fbta_pkg::ACT_CONS_SEM);
    is_set    = (act_r == fbta_pkg::ACT_SET_SEM) || (act_r == fbta_pkg::ACT_SET_PRE);
    is_claim  = (act_r == fbta_pkg::ACT_CLAIM_SEM) || (act_r == fbta_pkg::ACT_CLAIM_PRE);
    new_frame = (frm_r != last_r);
    ou        = is_sem ? sel_us : sel_up;
    tu        = is_sem ? sem_tot_r : pre_tot_r;
    gb        = is_sem ? sem_bud_r : pre_bud_r;
    own_rem   = remain(ou, own_bud_r);
    glob_rem  = remain(tu, gb);
    mrem      = (own_rem < glob_rem) ? own_rem : glob_rem;
    grant_v   = (amt_r < {{(AW-BW){1'b0}}, mrem}) ? amt_r[BW-1:0] : mrem;
    tot_new   = sat_add(tu, amt_r, gb);
    own_new   = sat_add(ou, amt_r, own_bud_r);
    in_g      = 1'b0;
    for (int j = 0; j < G; j++) begin
      if (is_sem) begin
        in_g = in_g | ((GCW'(j) < sem_gcnt_r) && (sem_gid_r[j] == id_r));
      end else begin
        in_g = in_g | ((GCW'(j) < pre_gcnt_r) && (pre_gid_r[j] == id_r));
      end
    end
  end

  // scan step values
  logic scan_done, scan_pend;
  always_comb begin
    scan_done = (seen_r == count_r) || (gcnt_r == GCW'(G));
    scan_pend = sc_r ? cq[idx_r].pp : cq[idx_r].ps;
  end

  // cell write strobes
  always_comb begin
    used_val = own_new;
    for (int i = 0; i < N; i++) begin
      ctl[i] = '0;
      unique case (state_r)
        S_EXEC: begin
          if (act_r == fbta_pkg::ACT_REG) begin
            ctl[i].ld = (id_r != '0) && !found_r && (count_r < CW'(N)) &&
                        (CW'(i) == count_r);
          end else if (act_r == fbta_pkg::ACT_UNREG) begin
            ctl[i].sh = found_r && (IW'(i) >= kidx_r);
          end else if (act_r == fbta_pkg::ACT_SET_SEM) begin
            ctl[i].wps = match_r[i];
          end else if (act_r == fbta_pkg::ACT_SET_PRE) begin
            ctl[i].wpp = match_r[i];
          end
        end
        S_FRAME: ctl[i].clr = 1'b1;
        S_FIN: begin
          ctl[i].wus = match_r[i] && (act_r == fbta_pkg::ACT_CONS_SEM);
          ctl[i].wup = match_r[i] && (act_r == fbta_pkg::ACT_CONS_PRE);
        end
        default: ctl[i] = '0;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: begin
        if ((act_r == fbta_pkg::ACT_REG) || (act_r == fbta_pkg::ACT_UNREG)) begin
          state_nxt = S_RESP;
        end else if (is_set) begin
          state_nxt = (found_r && new_frame) ? S_FRAME : S_RESP;
        end else begin
          state_nxt = new_frame ? S_FRAME : S_FIN;
        end
      end
      S_FRAME: state_nxt = S_SCAN;
      S_SCAN: if (scan_done && sc_r) state_nxt = is_set ? S_RESP : S_FIN;
      S_FIN:  state_nxt = S_RESP;
      S_RESP: if (!out_v_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      sem_bud_r  <= fbta_pkg::GLOBAL_BUDGET_RST;
      pre_bud_r  <= fbta_pkg::GLOBAL_BUDGET_RST;
      own_bud_r  <= fbta_pkg::OWNER_BUDGET_RST;
      count_r    <= '0;
      sem_tot_r  <= '0;
      pre_tot_r  <= '0;
      sem_cur_r  <= '0;
      pre_cur_r  <= '0;
      last_r     <= '1;
      sem_gcnt_r <= '0;
      pre_gcnt_r <= '0;
      sc_r       <= 1'b0;
      idx_r      <= '0;
      seen_r     <= '0;
      gcnt_r     <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          fbta_pkg::CFG_SEM_BUDGET:   sem_bud_r <= cfg_wdata;
          fbta_pkg::CFG_PRE_BUDGET:   pre_bud_r <= cfg_wdata;
          fbta_pkg::CFG_OWNER_BUDGET: own_bud_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_v_r && out_tready && (state_r != S_RESP)) out_v_r <= 1'b0;
      unique case (state_r)
        S_EXEC: begin
          if (act_r == fbta_pkg::ACT_REG) begin
            if ((id_r != '0) && !found_r && (count_r < CW'(N))) count_r <= count_r + 1'b1;
          end else if ((act_r == fbta_pkg::ACT_UNREG) && found_r) begin
            count_r <= count_r - 1'b1;
            if ({1'b0, sem_cur_r} == count_r - 1'b1) sem_cur_r <= '0;
            if ({1'b0, pre_cur_r} == count_r - 1'b1) pre_cur_r <= '0;
          end
        end
        S_FRAME: begin
          sem_tot_r <= '0;
          pre_tot_r <= '0;
          last_r    <= frm_r;
          sc_r      <= 1'b0;
          idx_r     <= sem_cur_r;
          seen_r    <= '0;
          gcnt_r    <= '0;
        end
        S_SCAN: begin
          if (scan_done) begin
            if (!sc_r) begin
              sem_gcnt_r <= gcnt_r;
              sem_cur_r  <= idx_r;
              sc_r       <= 1'b1;
              idx_r      <= pre_cur_r;
              seen_r     <= '0;
              gcnt_r     <= '0;
            end else begin
              pre_gcnt_r <= gcnt_r;
              pre_cur_r  <= idx_r;
            end
          end else begin
            if (scan_pend) gcnt_r <= gcnt_r + 1'b1;
            idx_r  <= ({1'b0, idx_r} == count_r - 1'b1) ? '0 : idx_r + 1'b1;
            seen_r <= seen_r + 1'b1;
          end
        end
        S_FIN: begin
          if (!is_claim) begin
            if (is_sem) sem_tot_r <= tot_new;
            else        pre_tot_r <= tot_new;
          end
        end
        S_RESP: if (!out_v_r || out_tready) out_v_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      act_r  <= fbta_pkg::action_t'(in_tuser);
      id_r   <= in_tdata[63:0];
      flag_r <= in_tdata[64];
      amt_r  <= in_tdata[96:65];
      frm_r  <= in_tdata[160:97];
    end
    if (state_r == S_LOOK) begin
      match_r <= matchv;
      found_r <= |matchv;
      kidx_r  <= kenc;
    end
    if (state_r == S_SCAN && !scan_done && scan_pend) begin
      if (sc_r) pre_gid_r[gcnt_r[GIW-1:0]] <= cq[idx_r].id;
      else      sem_gid_r[gcnt_r[GIW-1:0]] <= cq[idx_r].id;
    end
    if (state_r == S_EXEC) begin
      res_g_r <= '0;
      if (act_r == fbta_pkg::ACT_REG) begin
        if ((id_r == '0) || found_r)  res_st_r <= fbta_pkg::ST_IGNORED;
        else if (count_r >= CW'(N))   res_st_r <= fbta_pkg::ST_FULL;
        else                          res_st_r <= fbta_pkg::ST_DONE;
      end else begin
        res_st_r <= found_r ? fbta_pkg::ST_DONE : fbta_pkg::ST_IGNORED;
      end
    end
    if (state_r == S_FIN) begin
      if (is_claim) begin
        if (!found_r || !(is_sem ? sel_ps : sel_pp) || !in_g) begin
          res_g_r  <= '0;
          res_st_r <= fbta_pkg::ST_IGNORED;
        end else begin
          res_g_r  <= grant_v;
          res_st_r <= fbta_pkg::ST_DONE;
        end
      end else begin
        res_g_r  <= '0;
        res_st_r <= found_r ? fbta_pkg::ST_DONE : fbta_pkg::ST_IGNORED;
      end
    end
    if (state_r == S_RESP && (!out_v_r || out_tready)) begin
      out_g_r  <= res_g_r;
      out_st_r <= res_st_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_st_r, out_g_r};

  // table occupancy never exceeds its size
  a_count: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(N))
    else $error("owner count overflow");
  // grant lists never exceed their length
  a_gcnt: assert property (@(posedge clk) disable iff (!rst_n)
    (sem_gcnt_r <= GCW'(G)) && (pre_gcnt_r <= GCW'(G)))
    else $error("grant count overflow");
  // cursors stay inside the occupied table
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ((count_r == '0) && (sem_cur_r == '0) && (pre_cur_r == '0)) ||
      (({1'b0, sem_cur_r} < count_r) && ({1'b0, pre_cur_r} < count_r)))
    else $error("scan cursor out of range");

endmodule
`default_nettype wire

// ----- test/frame_time_budget_arbiter_tb.sv -----
// Testbench for the frame time budget arbiter: directed and random items against a predictor.
`default_nettype none
module frame_time_budget_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;

  frame_time_budget_arbiter dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [15:0]       granted;
    fbta_pkg::status_t status;
  } grant_result_t;

  // predictor state
  logic [15:0] bud_sem, bud_pre, bud_own;
  logic [63:0] tbl_id [fbta_pkg::MAX_OWNERS];
  logic        tbl_ps [fbta_pkg::MAX_OWNERS];
  logic        tbl_pp [fbta_pkg::MAX_OWNERS];
  logic [15:0] tbl_us [fbta_pkg::MAX_OWNERS];
  logic [15:0] tbl_up [fbta_pkg::MAX_OWNERS];
  int          n_owners;
  logic [15:0] tot_sem, tot_pre;
  int          cur_sem, cur_pre;
  logic [63:0] frame_seen;
  logic [63:0] gl_sem [$];
  logic [63:0] gl_pre [$];

  grant_result_t expected_results [$];
  int  errors = 0;
  int  cycles = 0;
  bit  stall_in_en = 1'b1, stall_out_en = 1'b1;
  logic [63:0] cur_frame = 64'd1;
  logic [63:0] known_ids [$];

  function automatic int find_owner(logic [63:0] id);
    for (int i = 0; i < n_owners; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  // round-robin grant scan for one class
  function automatic void scan_grants(bit sem);
    int idx, seen;
    logic [63:0] picks [$];
    if (n_owners == 0) begin
      if (sem) begin gl_sem = {}; cur_sem = 0; end
      else begin gl_pre = {}; cur_pre = 0; end
      return;
    end
    idx = (sem ? cur_sem : cur_pre) % n_owners;
    seen = 0;
    while (seen < n_owners && picks.size() < fbta_pkg::GRANTS) begin
      if (sem ? tbl_ps[idx] : tbl_pp[idx]) picks = {picks, tbl_id[idx]};
      idx = (idx + 1) % n_owners;
      seen++;
    end
    if (sem) begin gl_sem = picks; cur_sem = idx; end
    else begin gl_pre = picks; cur_pre = idx; end
  endfunction

  function automatic void new_frame_check(logic [63:0] frame);
    if (frame == frame_seen) return;
    frame_seen = frame;
    tot_sem = 0;
    tot_pre = 0;
    for (int i = 0; i < fbta_pkg::MAX_OWNERS; i++) begin
      tbl_us[i] = 0;
      tbl_up[i] = 0;
    end
    scan_grants(1'b1);
    scan_grants(1'b0);
  endfunction

  function automatic logic [15:0] add_sat(logic [15:0] used, logic [31:0] amt, logic [15:0] b);
    logic [32:0] s;
    s = {17'b0, used} + {1'b0, amt};
    return (s > {17'b0, b}) ? b : s[15:0];
  endfunction

  function automatic logic [31:0] left_of(logic [15:0] used, logic [15:0] b);
    return b - ((used < b) ? used : b);
  endfunction

  function automatic bit granted_to(logic [63:0] q [$], logic [63:0] id);
    foreach (q[i]) if (q[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic grant_result_t predict_grant(fbta_pkg::action_t act, logic [63:0] id,
                                                  logic flag, logic [31:0] amt,
                                                  logic [63:0] frame);
    grant_result_t r;
    int k;
    bit sem;
    logic [31:0] g, own, glob;
    r.granted = 0;
    r.status = fbta_pkg::ST_DONE;
    k = find_owner(id);
    sem = (act == fbta_pkg::ACT_SET_SEM || act == fbta_pkg::ACT_CLAIM_SEM ||
           act == fbta_pkg::ACT_CONS_SEM);
    case (act)
      fbta_pkg::ACT_REG: begin
        if (id == 0 || k >= 0) r.status = fbta_pkg::ST_IGNORED;
        else if (n_owners >= fbta_pkg::MAX_OWNERS) r.status = fbta_pkg::ST_FULL;
        else begin
          tbl_id[n_owners] = id;
          tbl_ps[n_owners] = 0;
          tbl_pp[n_owners] = 0;
          tbl_us[n_owners] = 0;
          tbl_up[n_owners] = 0;
          n_owners++;
        end
      end
      fbta_pkg::ACT_UNREG: begin
        if (k < 0) r.status = fbta_pkg::ST_IGNORED;
        else begin
          for (int i = k; i + 1 < n_owners; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_ps[i] = tbl_ps[i+1];
            tbl_pp[i] = tbl_pp[i+1];
            tbl_us[i] = tbl_us[i+1];
            tbl_up[i] = tbl_up[i+1];
          end
          n_owners--;
          if (n_owners == 0) begin
            cur_sem = 0;
            cur_pre = 0;
          end else begin
            cur_sem = cur_sem % n_owners;
            cur_pre = cur_pre % n_owners;
          end
        end
      end
      fbta_pkg::ACT_SET_SEM, fbta_pkg::ACT_SET_PRE: begin
        if (k < 0) r.status = fbta_pkg::ST_IGNORED;
        else begin
          if (sem) tbl_ps[k] = flag;
          else tbl_pp[k] = flag;
          new_frame_check(frame);
        end
      end
      fbta_pkg::ACT_CLAIM_SEM, fbta_pkg::ACT_CLAIM_PRE: begin
        new_frame_check(frame);
        if (k < 0 || !(sem ? tbl_ps[k] : tbl_pp[k]) ||
            !granted_to(sem ? gl_sem : gl_pre, id)) begin
          r.status = fbta_pkg::ST_IGNORED;
        end else begin
          own = left_of(sem ? tbl_us[k] : tbl_up[k], bud_own);
          glob = sem ? left_of(tot_sem, bud_sem) : left_of(tot_pre, bud_pre);
          g = amt;
          if (own < g) g = own;
          if (glob < g) g = glob;
          r.granted = g[15:0];
        end
      end
      default: begin
        new_frame_check(frame);
        if (sem) tot_sem = add_sat(tot_sem, amt, bud_sem);
        else tot_pre = add_sat(tot_pre, amt, bud_pre);
        if (k < 0) r.status = fbta_pkg::ST_IGNORED;
        else if (sem) tbl_us[k] = add_sat(tbl_us[k], amt, bud_own);
        else tbl_up[k] = add_sat(tbl_up[k], amt, bud_own);
      end
    endcase
    return r;
  endfunction

  // send one item, then sometimes a random idle burst
  task automatic send_item(fbta_pkg::action_t act, logic [63:0] id, logic flag,
                           logic [31:0] amt, logic [63:0] frame);
    grant_result_t r;
    in_tdata <= {frame, amt, flag, id};
    in_tuser <= act;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_grant(act, id, flag, amt, frame);
    expected_results = {expected_results, r};
    @(negedge clk);
    if (stall_in_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_budget(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fbta_pkg::CFG_SEM_BUDGET: bud_sem = v;
      fbta_pkg::CFG_PRE_BUDGET: bud_pre = v;
      default: bud_own = v;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    grant_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[15:0] !== exp_r.granted) begin
          $error("granted_usec expected %0d actual %0d", exp_r.granted, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[17:16] !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_tdata[17:16]);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!stall_out_en) out_tready <= 1'b1;
    else if ($urandom_range(0, 7) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) out_tready <= 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] pick_id();
    if (known_ids.size() != 0 && $urandom_range(0, 9) != 0)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [63:0] big;
    big = 64'hFFFF_FFFF_FFFF_FFFE;
    send_item(fbta_pkg::ACT_REG, 64'd0, 1'b0, 32'd0, cur_frame);
    send_item(fbta_pkg::ACT_REG, 64'd5, 1'b1, 32'hFFFF_FFFF, cur_frame);
    send_item(fbta_pkg::ACT_REG, 64'd5, 1'b0, 32'd0, cur_frame);
    send_item(fbta_pkg::ACT_REG, big, 1'b0, 32'd0, cur_frame);
    send_item(fbta_pkg::ACT_SET_SEM, 64'd9, 1'b1, 32'd0, cur_frame);
    send_item(fbta_pkg::ACT_SET_SEM, 64'd5, 1'b1, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(fbta_pkg::ACT_SET_PRE, big, 1'b1, 32'd0, 64'd2);
    send_item(fbta_pkg::ACT_CLAIM_SEM, 64'd5, 1'b0, 32'hFFFF_FFFF, 64'd3);
    send_item(fbta_pkg::ACT_CLAIM_PRE, big, 1'b0, 32'd10, 64'd3);
    send_item(fbta_pkg::ACT_CONS_SEM, 64'd5, 1'b0, 32'hFFFF_FFFF, 64'd3);
    send_item(fbta_pkg::ACT_CLAIM_SEM, 64'd5, 1'b0, 32'd100, 64'd3);
    send_item(fbta_pkg::ACT_CONS_PRE, 64'd77, 1'b0, 32'd700, 64'd3);
    send_item(fbta_pkg::ACT_CLAIM_PRE, big, 1'b0, 32'hFFFF_FFFF, 64'd3);
    send_item(fbta_pkg::ACT_CLAIM_PRE, 64'd77, 1'b0, 32'd1, 64'd3);
    send_item(fbta_pkg::ACT_UNREG, 64'd77, 1'b0, 32'd0, 64'd3);
    send_item(fbta_pkg::ACT_UNREG, 64'd5, 1'b0, 32'd0, 64'd3);
    send_item(fbta_pkg::ACT_UNREG, big, 1'b0, 32'd0, 64'd3);
    for (int i = 1; i <= 17; i++) send_item(fbta_pkg::ACT_REG, 64'(i), 1'b0, 32'd0, 64'd3);
    send_item(fbta_pkg::ACT_SET_SEM, 64'd16, 1'b1, 32'd0, 64'd0);
    for (int i = 1; i <= 16; i++) known_ids = {known_ids, 64'(i)};
    known_ids = {known_ids, big};
    known_ids = {known_ids, 64'd0};
  endtask

  // random phase: mostly well-formed frames of pending/claim/consume
  task automatic test_random(int n_items);
    fbta_pkg::action_t act;
    logic [63:0] id;
    logic [31:0] amt;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 11) == 0) cur_frame = cur_frame + 1;
      if ($urandom_range(0, 60) == 0) cur_frame = {$urandom, $urandom};
      act = fbta_pkg::action_t'($urandom_range(0, 7));
      if (act inside {fbta_pkg::ACT_REG, fbta_pkg::ACT_UNREG} && $urandom_range(0, 1))
        act = fbta_pkg::ACT_SET_SEM;
      id = pick_id();
      case ($urandom_range(0, 3))
        0: amt = $urandom;
        1: amt = $urandom_range(0, 2500);
        default: amt = $urandom_range(0, 400);
      endcase
      send_item(act, id, $urandom_range(0, 3) != 0, amt, cur_frame);
    end
  endtask

  task automatic test_budgets(logic [15:0] s, logic [15:0] p, logic [15:0] o, int n);
    drain();
    write_budget(fbta_pkg::CFG_SEM_BUDGET, s);
    write_budget(fbta_pkg::CFG_PRE_BUDGET, p);
    write_budget(fbta_pkg::CFG_OWNER_BUDGET, o);
    test_random(n);
  endtask

  initial begin
    bud_sem = fbta_pkg::GLOBAL_BUDGET_RST;
    bud_pre = fbta_pkg::GLOBAL_BUDGET_RST;
    bud_own = fbta_pkg::OWNER_BUDGET_RST;
    n_owners = 0;
    tot_sem = 0;
    tot_pre = 0;
    cur_sem = 0;
    cur_pre = 0;
    frame_seen = '1;
    for (int i = 0; i < fbta_pkg::MAX_OWNERS; i++) begin
      tbl_us[i] = 0;
      tbl_up[i] = 0;
      tbl_ps[i] = 0;
      tbl_pp[i] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(150);
    test_budgets(16'd0, 16'd0, 16'd0, 80);
    test_budgets(16'hFFFF, 16'hFFFF, 16'hFFFF, 150);
    test_budgets(16'd300, 16'hA5A5, 16'd120, 150);
    test_budgets(16'd2000, 16'd2000, 16'd1000, 150);
    stall_in_en = 1'b0;
    stall_out_en = 1'b0;
    test_random(150);
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
